// ----- rtl/c2sa_pkg.sv -----
// ----------------------------------------------------------------------------
// c2sa_pkg
// Shared widths, selector codes, angle table and helpers for the
// Cartesian to spherical angle converter.
// ----------------------------------------------------------------------------
package c2sa_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int SEL_W   = 3;
  localparam int TURN_W  = 32;

  // Square root unit: one result bit per stage
  localparam int SQ_IN_W   = 64;
  localparam int SQ_STEPS  = SQ_IN_W / 2;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_REM_W  = 34;
  localparam int SQ_LAT    = SQ_STEPS;

  // CORDIC vectoring unit
  localparam int CD_IN_W   = 33;
  localparam int CD_STEPS  = 32;
  localparam int CD_XY_W   = 45;
  localparam int CD_ACC_W  = 34;
  localparam int CD_SH_W   = 6;
  localparam int CD_NORM   = 40;
  localparam int CD_LAT    = CD_STEPS + 4;

  // Normalization target for the distance-based angles
  localparam int NORM_MSB  = 29;
  localparam int SCALED_W  = 30;

  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [TURN_W-1:0] ROUND_HALF   = 32'd1 << (TURN_W - 1 - ANGLE_W);

  // Axis selector codes
  localparam logic [SEL_W-1:0] AXIS_X  = 3'd0;
  localparam logic [SEL_W-1:0] AXIS_Y  = 3'd1;
  localparam logic [SEL_W-1:0] AXIS_Z  = 3'd2;
  localparam logic [SEL_W-1:0] AXIS_NX = 3'd3;
  localparam logic [SEL_W-1:0] AXIS_NY = 3'd4;
  localparam logic [SEL_W-1:0] AXIS_NZ = 3'd5;

  // Register indexes
  localparam logic [1:0] REG_UP    = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_FWD   = 2'd2;

  // Front-end data carried alongside the square root units
  typedef struct packed {
    logic                     v;
    logic                     zd;
    logic                     zh;
    logic signed [COORD_W:0]  f;
    logic signed [COORD_W:0]  r;
    logic signed [COORD_W:0]  u;
    logic signed [SCALED_W:0] sf;
    logic signed [SCALED_W:0] su;
  } side_t;

  // Data carried alongside the CORDIC units
  typedef struct packed {
    logic               v;
    logic               zd;
    logic               zh;
    logic               rpos;
    logic               fneg;
    logic [COORD_W-1:0] radial;
  } post_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [TURN_W-1:0] turn_atan(input int i);
    logic [TURN_W-1:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Pick a signed component by selector; unused codes give zero
  function automatic logic signed [31:0] choose_axis(input logic [SEL_W-1:0] sel,
                                                     input logic signed [31:0] x,
                                                     input logic signed [31:0] y,
                                                     input logic signed [31:0] z);
    logic signed [31:0] c;
    case (sel)
      AXIS_X:  c = x;
      AXIS_Y:  c = y;
      AXIS_Z:  c = z;
      AXIS_NX: c = -x;
      AXIS_NY: c = -y;
      AXIS_NZ: c = -z;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Pick the square of the selected component
  function automatic logic [2*SCALED_W-1:0] choose_square(input logic [SEL_W-1:0] sel,
                                                          input logic [2*SCALED_W-1:0] a,
                                                          input logic [2*SCALED_W-1:0] b,
                                                          input logic [2*SCALED_W-1:0] c);
    logic [2*SCALED_W-1:0] q;
    case (sel) inside
      AXIS_X, AXIS_NX: q = a;
      AXIS_Y, AXIS_NY: q = b;
      AXIS_Z, AXIS_NZ: q = c;
      default:         q = '0;
    endcase
    return q;
  endfunction

  // Index of the highest set bit
  function automatic logic [5:0] msb_index(input logic [39:0] v);
    logic [5:0] m;
    m = '0;
    for (int i = 0; i < 40; i++) begin
      if (v[i]) m = 6'(i);
    end
    return m;
  endfunction

  // Round a 32-bit turn to the output angle width, wrapping
  function automatic logic [ANGLE_W-1:0] to_angle(input logic [TURN_W-1:0] a);
    logic [TURN_W-1:0] s;
    s = a + ROUND_HALF;
    return s[TURN_W-1 -: ANGLE_W];
  endfunction

endpackage

// ----- rtl/cartesian_to_spherical_angles.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_spherical_angles
// Converts a signed x,y,z triple to distance and five turn-fraction angles.
// ----------------------------------------------------------------------------
// One item enters per clock unless the pipeline holds; it passes 8 front
// stages (axis select, squares, normalization, radicands), a 32-stage square
// root pipeline, a 36-stage CORDIC pipeline and the output register. Five
// square root units and five CORDIC units run side by side. When the result
// at the output is not taken, the whole pipeline holds and s_tready drops
// in the same cycle. Axis selectors come from the APB registers and should
// only be changed while no item is in flight.
module cartesian_to_spherical_angles (
  input  logic         clk,
  input  logic         rst,
  // Input stream; tdata: coord_x[23:0], coord_y[47:24], coord_z[71:48]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,
  // Result stream; tdata: radial_distance[23:0], azimuth_angle[39:24],
  // elevation_angle[55:40], interaural_azimuth[71:56],
  // interaural_elevation[87:72], forward_axis_angle[103:88]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  // tuser: zero_distance_flag[0], zero_horizontal_flag[1]
  output logic [1:0]   m_tuser,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = c2sa_pkg::COORD_W;
  localparam int SW = c2sa_pkg::SCALED_W;
  localparam int AW = c2sa_pkg::ANGLE_W;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [c2sa_pkg::SEL_W-1:0] up_sel, right_sel, fwd_sel;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_sel    <= c2sa_pkg::AXIS_Z;
      right_sel <= c2sa_pkg::AXIS_NY;
      fwd_sel   <= c2sa_pkg::AXIS_X;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        c2sa_pkg::REG_UP:    up_sel    <= pwdata[c2sa_pkg::SEL_W-1:0];
        c2sa_pkg::REG_RIGHT: right_sel <= pwdata[c2sa_pkg::SEL_W-1:0];
        c2sa_pkg::REG_FWD:   fwd_sel   <= pwdata[c2sa_pkg::SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      c2sa_pkg::REG_UP:    prdata = 32'(up_sel);
      c2sa_pkg::REG_RIGHT: prdata = 32'(right_sel);
      c2sa_pkg::REG_FWD:   prdata = 32'(fwd_sel);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture input
  // --------------------------------------------------------------------------
  logic                 v1;
  logic signed [CW-1:0] x1, y1, z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= s_tdata[CW-1:0];
      y1 <= s_tdata[2*CW-1:CW];
      z1 <= s_tdata[3*CW-1:2*CW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: axis select and magnitudes
  // --------------------------------------------------------------------------
  logic                 v2, zd2, zh2, xn2, yn2, zn2;
  logic signed [CW:0]   f2, r2, u2;
  logic [CW-1:0]        mx2, my2, mz2;
  logic signed [CW:0]   f_c, r_c;

  assign f_c = (CW+1)'(c2sa_pkg::choose_axis(fwd_sel, 32'(x1), 32'(y1), 32'(z1)));
  assign r_c = (CW+1)'(c2sa_pkg::choose_axis(right_sel, 32'(x1), 32'(y1), 32'(z1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2  <= f_c;
      r2  <= r_c;
      u2  <= (CW+1)'(c2sa_pkg::choose_axis(up_sel, 32'(x1), 32'(y1), 32'(z1)));
      mx2 <= x1[CW-1] ? CW'(-x1) : CW'(x1);
      my2 <= y1[CW-1] ? CW'(-y1) : CW'(y1);
      mz2 <= z1[CW-1] ? CW'(-z1) : CW'(z1);
      xn2 <= x1[CW-1];
      yn2 <= y1[CW-1];
      zn2 <= z1[CW-1];
      zd2 <= (x1 == '0) && (y1 == '0) && (z1 == '0);
      zh2 <= (f_c == '0) && (r_c == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares of the raw magnitudes, largest magnitude
  // --------------------------------------------------------------------------
  logic                 v3, zd3, zh3, xn3, yn3, zn3;
  logic signed [CW:0]   f3, r3, u3;
  logic [CW-1:0]        mx3, my3, mz3, big3;
  logic [2*CW-1:0]      qx3, qy3, qz3;
  logic [CW-1:0]        bxy;

  assign bxy = (mx2 > my2) ? mx2 : my2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx3  <= mx2 * mx2;
      qy3  <= my2 * my2;
      qz3  <= mz2 * mz2;
      big3 <= (mz2 > bxy) ? mz2 : bxy;
      {mx3, my3, mz3} <= {mx2, my2, mz2};
      {xn3, yn3, zn3} <= {xn2, yn2, zn2};
      {f3, r3, u3}    <= {f2, r2, u2};
      zd3 <= zd2;
      zh3 <= zh2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum of squares, normalization shift
  // --------------------------------------------------------------------------
  logic                 v4, zd4, zh4, xn4, yn4, zn4;
  logic signed [CW:0]   f4, r4, u4;
  logic [CW-1:0]        mx4, my4, mz4;
  logic [2*CW-1:0]      n4;
  logic [4:0]           sh4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n4  <= qx3 + qy3 + qz3;
      sh4 <= 5'(6'(c2sa_pkg::NORM_MSB) - c2sa_pkg::msb_index(40'(big3)));
      {mx4, my4, mz4} <= {mx3, my3, mz3};
      {xn4, yn4, zn4} <= {xn3, yn3, zn3};
      {f4, r4, u4}    <= {f3, r3, u3};
      zd4 <= zd3;
      zh4 <= zh3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: scaled magnitudes
  // --------------------------------------------------------------------------
  logic                 v5, zd5, zh5, xn5, yn5, zn5;
  logic signed [CW:0]   f5, r5, u5;
  logic [SW-1:0]        sx5, sy5, sz5;
  logic [2*CW-1:0]      n5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx5 <= SW'(mx4) << sh4;
      sy5 <= SW'(my4) << sh4;
      sz5 <= SW'(mz4) << sh4;
      n5  <= n4;
      {xn5, yn5, zn5} <= {xn4, yn4, zn4};
      {f5, r5, u5}    <= {f4, r4, u4};
      zd5 <= zd4;
      zh5 <= zh4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: scaled squares, scaled forward and up
  // --------------------------------------------------------------------------
  logic                 v6, zd6, zh6;
  logic signed [CW:0]   f6, r6, u6;
  logic signed [SW:0]   sf6, su6;
  logic [2*SW-1:0]      qx6, qy6, qz6;
  logic [2*CW-1:0]      n6;
  logic signed [31:0]   ssx, ssy, ssz;

  assign ssx = xn5 ? -$signed(32'(sx5)) : $signed(32'(sx5));
  assign ssy = yn5 ? -$signed(32'(sy5)) : $signed(32'(sy5));
  assign ssz = zn5 ? -$signed(32'(sz5)) : $signed(32'(sz5));

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx6 <= sx5 * sx5;
      qy6 <= sy5 * sy5;
      qz6 <= sz5 * sz5;
      sf6 <= (SW+1)'(c2sa_pkg::choose_axis(fwd_sel, ssx, ssy, ssz));
      su6 <= (SW+1)'(c2sa_pkg::choose_axis(up_sel, ssx, ssy, ssz));
      n6  <= n5;
      {f6, r6, u6} <= {f5, r5, u5};
      zd6 <= zd5;
      zh6 <= zh5;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: scaled d^2, f^2, u^2
  // --------------------------------------------------------------------------
  logic                 v7, zd7, zh7;
  logic signed [CW:0]   f7, r7, u7;
  logic signed [SW:0]   sf7, su7;
  logic [2*SW+1:0]      d2_7;
  logic [2*SW-1:0]      ff7, uu7;
  logic [2*CW-1:0]      n7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_7 <= (2*SW+2)'(qx6) + (2*SW+2)'(qy6) + (2*SW+2)'(qz6);
      ff7  <= c2sa_pkg::choose_square(fwd_sel, qx6, qy6, qz6);
      uu7  <= c2sa_pkg::choose_square(up_sel, qx6, qy6, qz6);
      n7   <= n6;
      {sf7, su7}   <= {sf6, su6};
      {f7, r7, u7} <= {f6, r6, u6};
      zd7 <= zd6;
      zh7 <= zh6;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: radicands
  // --------------------------------------------------------------------------
  localparam int QW = c2sa_pkg::SQ_IN_W;
  logic             v8;
  logic [QW-1:0]    rad_dist, rad_el, rad_rest, rad_fu, rad_fwd;
  c2sa_pkg::side_t  side8;
  logic [2*SW+1:0]  fu_c;

  assign fu_c = (2*SW+2)'(ff7) + (2*SW+2)'(uu7);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_dist <= QW'(n7);
      rad_el   <= QW'(d2_7 - (2*SW+2)'(uu7));
      rad_fu   <= QW'(fu_c);
      rad_rest <= (d2_7 > fu_c) ? QW'(d2_7 - fu_c) : '0;
      rad_fwd  <= QW'(d2_7 - (2*SW+2)'(ff7));
      side8.zd <= zd7;
      side8.zh <= zh7;
      side8.f  <= f7;
      side8.r  <= r7;
      side8.u  <= u7;
      side8.sf <= sf7;
      side8.su <= su7;
    end
  end

  // Attach the stage valid in place of the unused side valid bit
  c2sa_pkg::side_t side8_v;
  assign side8_v = c2sa_pkg::side_t'({v8, side8[$bits(c2sa_pkg::side_t)-2:0]});

  // --------------------------------------------------------------------------
  // Square root pipelines
  // --------------------------------------------------------------------------
  localparam int RW = c2sa_pkg::SQ_ROOT_W;
  logic [RW-1:0] rt_dist, rt_el, rt_rest, rt_fu, rt_fwd;
  logic [c2sa_pkg::SQ_REM_W-1:0] rm_dist, rm_el, rm_rest, rm_fu, rm_fwd;

  c2sa_sqrt u_sq_dist (.clk, .en, .radicand(rad_dist), .root(rt_dist), .rem(rm_dist));
  c2sa_sqrt u_sq_el   (.clk, .en, .radicand(rad_el),   .root(rt_el),   .rem(rm_el));
  c2sa_sqrt u_sq_rest (.clk, .en, .radicand(rad_rest), .root(rt_rest), .rem(rm_rest));
  c2sa_sqrt u_sq_fu   (.clk, .en, .radicand(rad_fu),   .root(rt_fu),   .rem(rm_fu));
  c2sa_sqrt u_sq_fwd  (.clk, .en, .radicand(rad_fwd),  .root(rt_fwd),  .rem(rm_fwd));

  // Carry side data along the square root pipelines
  c2sa_pkg::side_t sdl [c2sa_pkg::SQ_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < c2sa_pkg::SQ_LAT; i++) sdl[i].v <= 1'b0;
    end else if (en) begin
      sdl[0] <= side8_v;
      for (int i = 1; i < c2sa_pkg::SQ_LAT; i++) sdl[i] <= sdl[i-1];
    end
  end

  c2sa_pkg::side_t sq_side;
  assign sq_side = sdl[c2sa_pkg::SQ_LAT-1];

  // --------------------------------------------------------------------------
  // CORDIC pipelines
  // --------------------------------------------------------------------------
  localparam int IW = c2sa_pkg::CD_IN_W;
  logic [c2sa_pkg::TURN_W-1:0] t_az, t_el, t_iaz, t_iel, t_fwd;

  c2sa_cordic u_cd_az (
    .clk, .en, .y_in(IW'(sq_side.r)), .x_in(IW'(sq_side.f)), .turn(t_az)
  );
  c2sa_cordic u_cd_el (
    .clk, .en, .y_in(IW'(sq_side.su)), .x_in($signed(IW'(rt_el))), .turn(t_el)
  );
  c2sa_cordic u_cd_iaz (
    .clk, .en, .y_in($signed(IW'(rt_rest))), .x_in($signed(IW'(rt_fu))), .turn(t_iaz)
  );
  c2sa_cordic u_cd_iel (
    .clk, .en, .y_in(IW'(sq_side.u)), .x_in(IW'(sq_side.f)), .turn(t_iel)
  );
  c2sa_cordic u_cd_fwd (
    .clk, .en, .y_in($signed(IW'(rt_fwd))), .x_in(IW'(sq_side.sf)), .turn(t_fwd)
  );

  // Round the distance half up and carry flags along the CORDIC pipelines
  c2sa_pkg::post_t post_c;
  logic [RW-1:0]   dist_c;

  assign dist_c = rt_dist + RW'(32'(rm_dist) > 32'(rt_dist) || rm_dist[c2sa_pkg::SQ_REM_W-1 -:
                  (c2sa_pkg::SQ_REM_W - RW)] != '0);

  always_comb begin
    post_c.v      = sq_side.v;
    post_c.zd     = sq_side.zd;
    post_c.zh     = sq_side.zh;
    post_c.rpos   = sq_side.r > 0;
    post_c.fneg   = sq_side.f < 0;
    post_c.radial = CW'(dist_c);
  end

  c2sa_pkg::post_t pdl [c2sa_pkg::CD_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < c2sa_pkg::CD_LAT; i++) pdl[i].v <= 1'b0;
    end else if (en) begin
      pdl[0] <= post_c;
      for (int i = 1; i < c2sa_pkg::CD_LAT; i++) pdl[i] <= pdl[i-1];
    end
  end

  c2sa_pkg::post_t post;
  assign post = pdl[c2sa_pkg::CD_LAT-1];

  // --------------------------------------------------------------------------
  // Output register: round angles, apply special cases
  // --------------------------------------------------------------------------
  logic [c2sa_pkg::TURN_W-1:0] t_iaz_s, t_fwd_s;
  assign t_iaz_s = post.rpos ? t_iaz : '0 - t_iaz;
  assign t_fwd_s = t_fwd + (post.fneg ? c2sa_pkg::TURN_QUARTER : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= post.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[CW-1:0]          <= post.zd ? '0 : post.radial;
      m_tdata[CW+AW-1:CW]      <= post.zh ? '0 : c2sa_pkg::to_angle('0 - t_az);
      m_tdata[CW+2*AW-1:CW+AW] <= post.zd ? '0 : c2sa_pkg::to_angle(t_el);
      m_tdata[CW+3*AW-1:CW+2*AW] <= post.zd ? '0 : c2sa_pkg::to_angle(t_iaz_s);
      m_tdata[CW+4*AW-1:CW+3*AW] <= post.zd ? '0 : c2sa_pkg::to_angle(t_iel);
      m_tdata[CW+5*AW-1:CW+4*AW] <= post.zd ? '0 : c2sa_pkg::to_angle(t_fwd_s);
      m_tuser[0] <= post.zd;
      m_tuser[1] <= post.zh;
    end
  end

endmodule

// ----- rtl/c2sa_sqrt.sv -----
// ----------------------------------------------------------------------------
// c2sa_sqrt
// Pipelined floor square root, one result bit per stage, with remainder.
// ----------------------------------------------------------------------------
module c2sa_sqrt (
  input  logic                                clk,
  input  logic                                en,
  input  logic [c2sa_pkg::SQ_IN_W-1:0]        radicand,
  output logic [c2sa_pkg::SQ_ROOT_W-1:0]      root,
  output logic [c2sa_pkg::SQ_REM_W-1:0]       rem
);

  logic [c2sa_pkg::SQ_IN_W-1:0] num [c2sa_pkg::SQ_STEPS];
  logic [c2sa_pkg::SQ_IN_W-1:0] res [c2sa_pkg::SQ_STEPS];

  for (genvar k = 0; k < c2sa_pkg::SQ_STEPS; k++) begin : g_step
    localparam logic [c2sa_pkg::SQ_IN_W-1:0] BIT =
      c2sa_pkg::SQ_IN_W'(1) << (c2sa_pkg::SQ_IN_W - 2 - 2 * k);
    logic [c2sa_pkg::SQ_IN_W-1:0] n_in;
    logic [c2sa_pkg::SQ_IN_W-1:0] r_in;
    logic [c2sa_pkg::SQ_IN_W-1:0] trial;

    if (k == 0) begin : g_first
      assign n_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = num[k-1];
      assign r_in = res[k-1];
    end

    assign trial = r_in + BIT;

    // Try one root bit; subtract when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          num[k] <= n_in - trial;
          res[k] <= (r_in >> 1) + BIT;
        end else begin
          num[k] <= n_in;
          res[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root = res[c2sa_pkg::SQ_STEPS-1][c2sa_pkg::SQ_ROOT_W-1:0];
  assign rem  = num[c2sa_pkg::SQ_STEPS-1][c2sa_pkg::SQ_REM_W-1:0];

endmodule

// ----- rtl/c2sa_cordic.sv -----
// ----------------------------------------------------------------------------
// c2sa_cordic
// Pipelined CORDIC vectoring atan2, result in 2^-32 turns modulo one turn.
// ----------------------------------------------------------------------------
module c2sa_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [c2sa_pkg::CD_IN_W-1:0]  y_in,
  input  logic signed [c2sa_pkg::CD_IN_W-1:0]  x_in,
  output logic [c2sa_pkg::TURN_W-1:0]          turn
);

  localparam int W  = c2sa_pkg::CD_IN_W;
  localparam int XW = c2sa_pkg::CD_XY_W;
  localparam int AW = c2sa_pkg::CD_ACC_W;
  localparam int N  = c2sa_pkg::CD_STEPS;

  // Stage 0: magnitudes and quadrant
  logic [W-1:0] ax0, ay0, big0;
  logic         xp0, yp0, zr0;
  // Stage 1: shift amount
  logic [W-1:0] ax1, ay1;
  logic [c2sa_pkg::CD_SH_W-1:0] sh1;
  logic         xp1, yp1, zr1;
  // Iteration stages (index 0 holds the normalized vector)
  logic signed [XW-1:0] cx [N+1];
  logic signed [XW-1:0] cy [N+1];
  logic signed [AW-1:0] acc [N+1];
  logic                 xp [N+1];
  logic                 yp [N+1];
  logic                 zr [N+1];

  logic [W-1:0] ax_c, ay_c;
  assign ax_c = x_in[W-1] ? W'(-x_in) : W'(x_in);
  assign ay_c = y_in[W-1] ? W'(-y_in) : W'(y_in);

  // Fold to the first quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      ax0  <= ax_c;
      ay0  <= ay_c;
      big0 <= (ax_c > ay_c) ? ax_c : ay_c;
      xp0  <= !x_in[W-1];
      yp0  <= !y_in[W-1];
      zr0  <= (ax_c == '0) && (ay_c == '0);
    end
  end

  // Find the shift that lifts the larger magnitude to the normalized range
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= ax0;
      ay1 <= ay0;
      sh1 <= c2sa_pkg::CD_SH_W'(c2sa_pkg::CD_NORM) -
             c2sa_pkg::msb_index(40'(big0));
      xp1 <= xp0;
      yp1 <= yp0;
      zr1 <= zr0;
    end
  end

  // Apply the shift
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]  <= $signed(XW'(ax1) << sh1);
      cy[0]  <= $signed(XW'(ay1) << sh1);
      acc[0] <= '0;
      xp[0]  <= xp1;
      yp[0]  <= yp1;
      zr[0]  <= zr1;
    end
  end

  // Rotation steps
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [AW-1:0] ANG = AW'(c2sa_pkg::turn_atan(i));
    logic signed [XW-1:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1]  <= cx[i] + dx;
          cy[i+1]  <= cy[i] - dy;
          acc[i+1] <= acc[i] + ANG;
        end else begin
          cx[i+1]  <= cx[i] - dx;
          cy[i+1]  <= cy[i] + dy;
          acc[i+1] <= acc[i] - ANG;
        end
        xp[i+1] <= xp[i];
        yp[i+1] <= yp[i];
        zr[i+1] <= zr[i];
      end
    end
  end

  // Clamp to a quarter turn and unfold by quadrant
  logic signed [AW-1:0] acc_n;
  logic [c2sa_pkg::TURN_W-1:0] t_c, turn_next;
  assign acc_n = acc[N];

  always_comb begin
    if (acc_n < 0) begin
      t_c = '0;
    end else if (acc_n > $signed(AW'(c2sa_pkg::TURN_QUARTER))) begin
      t_c = c2sa_pkg::TURN_QUARTER;
    end else begin
      t_c = acc_n[c2sa_pkg::TURN_W-1:0];
    end
    if (zr[N]) begin
      turn_next = '0;
    end else if (xp[N]) begin
      turn_next = yp[N] ? t_c : '0 - t_c;
    end else begin
      turn_next = yp[N] ? c2sa_pkg::TURN_HALF - t_c : c2sa_pkg::TURN_HALF + t_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turn <= turn_next;
    end
  end

endmodule

// ----- bench/c2sa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2sa_checker
// Watches the coordinate, result and register ports, computes the expected
// distance and angles for every accepted item and compares each result.
// ----------------------------------------------------------------------------
module c2sa_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [23:0] radial;
    logic [15:0] az;
    logic [15:0] el;
    logic [15:0] iaz;
    logic [15:0] iel;
    logic [15:0] fwd;
    logic        zd;
    logic        zh;
  } angles_t;

  angles_t expected_angles[$];
  logic [2:0] up_sel, right_sel, fwd_sel;

  function automatic longint pick(logic [2:0] sel, longint x, longint y, longint z);
    case (sel)
      c2sa_pkg::AXIS_X:  return x;
      c2sa_pkg::AXIS_Y:  return y;
      c2sa_pkg::AXIS_Z:  return z;
      c2sa_pkg::AXIS_NX: return -x;
      c2sa_pkg::AXIS_NY: return -y;
      c2sa_pkg::AXIS_NZ: return -z;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] atan_entry(int i);
    logic [31:0] tbl [32];
    tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
            81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  // Arithmetic shift is floor division for signed operands
  function automatic logic [31:0] turn_of(longint y, longint x);
    longint unsigned ax, ay, big;
    longint cx, cy, acc, dx, dy;
    logic [31:0] t;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    if (ax == 0 && ay == 0) return 0;
    big = ax > ay ? ax : ay;
    while (big < (64'd1 << 40)) begin
      ax <<= 1; ay <<= 1; big <<= 1;
    end
    cx = ax; cy = ay; acc = 0;
    for (int i = 0; i < 32; i++) begin
      dx = cy >>> i;
      dy = longint'(longint'(cx) >>> i);
      if (cy > 0) begin
        cx += dx; cy -= dy; acc += atan_entry(i);
      end else begin
        cx -= dx; cy += dy; acc -= atan_entry(i);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'd1 << 30)) acc = 64'd1 << 30;
    t = acc[31:0];
    if (x >= 0) return y >= 0 ? t : 32'd0 - t;
    return y >= 0 ? c2sa_pkg::TURN_HALF - t : c2sa_pkg::TURN_HALF + t;
  endfunction

  function automatic logic [15:0] round_turn(logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h8000;
    return s[31:16];
  endfunction

  function automatic angles_t convert(logic [71:0] d);
    angles_t o;
    longint x, y, z, f, r, u, sx, sy, sz, sf, su;
    longint unsigned mx, my, mz, n, root_n, big, d2, f2, u2, fu2, rest;
    logic [31:0] t;
    x = longint'(signed'(d[23:0]));
    y = longint'(signed'(d[47:24]));
    z = longint'(signed'(d[71:48]));
    f = pick(fwd_sel, x, y, z);
    r = pick(right_sel, x, y, z);
    u = pick(up_sel, x, y, z);
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    mz = z < 0 ? -z : z;
    n = mx * mx + my * my + mz * mz;
    root_n = isqrt(n);
    if (n - root_n * root_n > root_n) root_n++;
    o = '0;
    o.zd = (n == 0);
    o.zh = (f == 0 && r == 0);
    if (!o.zh) o.az = round_turn(32'd0 - turn_of(r, f));
    if (!o.zd) begin
      o.radial = root_n[23:0];
      big = mx > my ? mx : my;
      if (mz > big) big = mz;
      while (big < (64'd1 << 29)) begin
        mx <<= 1; my <<= 1; mz <<= 1; big <<= 1;
      end
      while (big >= (64'd1 << 30)) begin
        mx >>= 1; my >>= 1; mz >>= 1; big >>= 1;
      end
      sx = x < 0 ? -longint'(mx) : longint'(mx);
      sy = y < 0 ? -longint'(my) : longint'(my);
      sz = z < 0 ? -longint'(mz) : longint'(mz);
      sf = pick(fwd_sel, sx, sy, sz);
      su = pick(up_sel, sx, sy, sz);
      d2 = mx * mx + my * my + mz * mz;
      f2 = sf * sf;
      u2 = su * su;
      o.el = round_turn(turn_of(su, longint'(isqrt(d2 - u2))));
      fu2 = f2 + u2;
      rest = d2 > fu2 ? d2 - fu2 : 0;
      t = turn_of(longint'(isqrt(rest)), longint'(isqrt(fu2)));
      if (!(r > 0)) t = 32'd0 - t;
      o.iaz = round_turn(t);
      o.iel = round_turn(turn_of(u, f));
      t = turn_of(longint'(isqrt(d2 - f2)), sf);
      if (f < 0) t += c2sa_pkg::TURN_QUARTER;
      o.fwd = round_turn(t);
    end
    return o;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk) begin
    angles_t got, want;
    if (rst) begin
      up_sel <= c2sa_pkg::AXIS_Z;
      right_sel <= c2sa_pkg::AXIS_NY;
      fwd_sel <= c2sa_pkg::AXIS_X;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          c2sa_pkg::REG_UP:    up_sel <= pwdata[2:0];
          c2sa_pkg::REG_RIGHT: right_sel <= pwdata[2:0];
          c2sa_pkg::REG_FWD:   fwd_sel <= pwdata[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_angles.push_back(convert(s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:0], m_tdata[39:24], m_tdata[55:40], m_tdata[71:56],
               m_tdata[87:72], m_tdata[103:88], m_tuser[0], m_tuser[1]};
        if (expected_angles.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_angles.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected d=%0d az=%h el=%h iaz=%h iel=%h fw=%h zd=%b zh=%b",
                       want.radial, want.az, want.el, want.iaz, want.iel, want.fwd,
                       want.zd, want.zh);
              $display("          actual d=%0d az=%h el=%h iaz=%h iel=%h fw=%h zd=%b zh=%b",
                       got.radial, got.az, got.el, got.iaz, got.iel, got.fwd,
                       got.zd, got.zh);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_angles.size();
    end
  end

endmodule

// ----- bench/cartesian_to_spherical_angles_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_angles_tb
// Drives directed and random coordinate triples under several axis mappings,
// with bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_angles_tb;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [71:0]  s_tdata;
  logic         m_tvalid, m_tready;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel, penable, pwrite, pready;
  logic [3:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending;
  int           hold_cycles;
  logic         hold_start, hold_used;
  logic         stall_mode;

  cartesian_to_spherical_angles dut (.*);

  c2sa_checker checker_i (.*);

  always begin
    clk = 1'b0; #10; clk = 1'b1; #10;
  end

  // Receiver: long hold-off once when asked, otherwise random stalls in stall mode or always ready
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cycles <= 0;
      hold_used <= 1'b0;
    end else if (hold_start && !hold_used) begin
      m_tready <= 1'b0;
      hold_cycles <= 300;
      hold_used <= 1'b1;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_mode) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_coord(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'(signed'($urandom_range(0, 40)) - 20);
      3: return 24'h0;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) == 0) gap();
        burst = $urandom_range(1, 30);
      end
      burst--;
      send_coord(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    logic [23:0] ext [4];
    ext = '{24'h800000, 24'h7fffff, 24'h000001, 24'hffffff};
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_start = 1'b0; stall_mode = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero vector, zero horizontal, axes and extremes
    send_coord(24'd0, 24'd0, 24'd0);
    send_coord(24'd0, 24'd0, 24'd5);
    send_coord(24'd0, 24'd0, 24'h800000);
    send_coord(24'd1, 24'd0, 24'd0);
    send_coord(24'hffffff, 24'd0, 24'd0);
    send_coord(24'd0, 24'd1, 24'd0);
    send_coord(24'd0, 24'hffffff, 24'd0);
    send_coord(24'd3, 24'd4, 24'd0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_coord(ext[i], ext[j], ext[(i + j) % 4]);
    drain();

    // Repeated and unused selectors
    write_reg(c2sa_pkg::REG_UP, c2sa_pkg::AXIS_X);
    write_reg(c2sa_pkg::REG_RIGHT, c2sa_pkg::AXIS_X);
    write_reg(c2sa_pkg::REG_FWD, 3'd7);
    send_coord(24'd0, 24'd9, 24'd9);
    send_coord(24'd100, 24'd1, 24'd2);
    drain();

    // Random phases over several mappings, extremes included
    stall_mode = 1'b1;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(c2sa_pkg::REG_UP, c2sa_pkg::AXIS_Z);
          write_reg(c2sa_pkg::REG_RIGHT, c2sa_pkg::AXIS_NY);
          write_reg(c2sa_pkg::REG_FWD, c2sa_pkg::AXIS_X);
        end
        1: begin
          write_reg(c2sa_pkg::REG_UP, c2sa_pkg::AXIS_NZ);
          write_reg(c2sa_pkg::REG_RIGHT, c2sa_pkg::AXIS_X);
          write_reg(c2sa_pkg::REG_FWD, c2sa_pkg::AXIS_NX);
        end
        2: begin
          write_reg(c2sa_pkg::REG_UP, c2sa_pkg::AXIS_Y);
          write_reg(c2sa_pkg::REG_RIGHT, c2sa_pkg::AXIS_NZ);
          write_reg(c2sa_pkg::REG_FWD, c2sa_pkg::AXIS_NY);
        end
        default: begin
          write_reg(c2sa_pkg::REG_UP, 3'($urandom_range(0, 7)));
          write_reg(c2sa_pkg::REG_RIGHT, 3'($urandom_range(0, 7)));
          write_reg(c2sa_pkg::REG_FWD, 3'($urandom_range(0, 7)));
        end
      endcase
      if (p == 1) hold_start = 1'b1;
      random_phase(p == 1 ? 200 : 190);
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- cartesian_to_spherical_angles.f -----
rtl/c2sa_pkg.sv
rtl/c2sa_sqrt.sv
rtl/c2sa_cordic.sv
rtl/cartesian_to_spherical_angles.sv
bench/c2sa_checker.sv
bench/cartesian_to_spherical_angles_tb.sv
